// ----- rtl/rcbem_pkg.sv -----
// ----------------------------------------------------------------------------
// rcbem_pkg
// Shared constants, codes and types of the region-checked big-endian memory.
// ----------------------------------------------------------------------------
package rcbem_pkg;

  localparam int DescRegs       = 4;
  localparam int CfgIdxW        = 2;
  localparam int DescW          = 64;
  localparam int RegionCountDef = 4;
  localparam int RegionBytesDef = 4096;
  localparam int LaneCount      = 8;

  localparam int DescSizeMsb = 44;
  localparam int DescSizeLsb = 32;
  localparam int DescSizeW   = DescSizeMsb - DescSizeLsb + 1;
  localparam int DescPermMsb = 47;
  localparam int DescPermLsb = 45;

  localparam logic [1:0] OpRead    = 2'd0;
  localparam logic [1:0] OpWrite   = 2'd1;
  localparam logic [1:0] OpPreload = 2'd2;
  localparam logic [1:0] OpProbe   = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [1:0] number;
    logic [2:0] perms;
  } region_res_t;

  function automatic logic [3:0] access_bytes(input logic [1:0] code);
    return 4'd1 << code;
  endfunction

endpackage

// ----- rtl/rcbem_ram.sv -----
// ----------------------------------------------------------------------------
// rcbem_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rcbem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rcbem_region.sv -----
// ----------------------------------------------------------------------------
// rcbem_region
// Parallel region match: picks the mapped region with the lowest base that
// holds the whole access and forms the byte index into the store.
// ----------------------------------------------------------------------------
module rcbem_region #(
  parameter int REGION_COUNT = rcbem_pkg::RegionCountDef,
  parameter int REGION_BYTES = rcbem_pkg::RegionBytesDef,
  localparam int NDesc = (REGION_COUNT < rcbem_pkg::DescRegs) ? REGION_COUNT
                                                               : rcbem_pkg::DescRegs,
  localparam int AW = $clog2(REGION_COUNT * REGION_BYTES)
) (
  input  logic [rcbem_pkg::DescW-1:0] desc_i [NDesc],
  input  logic [31:0]                 addr_i,
  input  logic [1:0]                  size_i,
  output rcbem_pkg::region_res_t      res_o,
  output logic [AW-1:0]               index_o
);

  localparam int SW = ($clog2(REGION_BYTES + 1) > rcbem_pkg::DescSizeW)
                    ? $clog2(REGION_BYTES + 1) : rcbem_pkg::DescSizeW;
  localparam logic [SW-1:0] RegionBytesW = SW'(REGION_BYTES);
  localparam logic [32:0]   SpaceEnd     = 33'h1_0000_0000;

  logic [31:0]      base   [NDesc];
  logic [SW-1:0]    raw_sz [NDesc];
  logic [SW-1:0]    eff_sz [NDesc];
  logic [32:0]      lim    [NDesc];
  logic [AW-1:0]    cand   [NDesc];
  logic [NDesc-1:0] hit_v;
  logic [NDesc-1:0] win;
  logic [32:0]      end_a;

  always_comb begin
    end_a = {1'b0, addr_i} + 33'(rcbem_pkg::access_bytes(size_i));
    for (int r = 0; r < NDesc; r++) begin
      base[r]   = desc_i[r][31:0];
      raw_sz[r] = SW'(desc_i[r][rcbem_pkg::DescSizeMsb:rcbem_pkg::DescSizeLsb]);
      eff_sz[r] = (raw_sz[r] > RegionBytesW) ? RegionBytesW : raw_sz[r];
      lim[r]    = {1'b0, base[r]} + 33'(eff_sz[r]);
      hit_v[r]  = (eff_sz[r] != '0) && (lim[r] <= SpaceEnd) &&
                  (addr_i >= base[r]) && (end_a <= lim[r]);
      cand[r]   = AW'(r * REGION_BYTES) + AW'(addr_i - base[r]);
    end
  end

  always_comb begin
    for (int r = 0; r < NDesc; r++) begin
      win[r] = hit_v[r];
      for (int s = 0; s < NDesc; s++) begin
        if (s != r && hit_v[s] &&
            !((base[r] < base[s]) || ((base[r] == base[s]) && (r < s)))) begin
          win[r] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res_o   = '0;
    index_o = '0;
    for (int r = 0; r < NDesc; r++) begin
      if (win[r]) begin
        res_o.hit    = 1'b1;
        res_o.number = 2'(r);
        res_o.perms  = desc_i[r][rcbem_pkg::DescPermMsb:rcbem_pkg::DescPermLsb];
        index_o      = cand[r];
      end
    end
  end

endmodule

// ----- rtl/region_checked_big_endian_memory.sv -----
// ----------------------------------------------------------------------------
// region_checked_big_endian_memory
// Byte store of an emulated big-endian machine behind up to four permission
// checked region descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an access is taken at a rising edge with start high and
//   busy low (operation, address, access_size, write_data).
//   Result channel: result_valid_o is high for one cycle with ok, read_data,
//   region_hit, region_number and region_perms; the receiver cannot stall.
//   Config port: cfg_we_i writes descriptor cfg_index_i at any time; write
//   only while no access is in flight.
//   Sequence: after the accepting edge an access goes through region match
//   (SLookup), byte-lane RAM access (SAccess) and read-back (SResp), where
//   the result strobe is given; busy then drops.
//   The store is eight byte-lane RAMs so an unaligned 8-byte access needs
//   a single access to each lane RAM.
//   Reset: descriptors clear to zero (all regions unmapped) and a clearing
//   pass zeroes every row of the store while busy stays high.
// ----------------------------------------------------------------------------
module region_checked_big_endian_memory #(
  parameter int REGION_COUNT = rcbem_pkg::RegionCountDef,
  parameter int REGION_BYTES = rcbem_pkg::RegionBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic [31:0]                   address_i,
  input  logic [1:0]                    access_size_i,
  input  logic [63:0]                   write_data_i,
  input  logic                          cfg_we_i,
  input  logic [rcbem_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rcbem_pkg::DescW-1:0]   cfg_wdata_i,
  output logic                          result_valid_o,
  output logic                          ok_o,
  output logic [63:0]                   read_data_o,
  output logic                          region_hit_o,
  output logic [1:0]                    region_number_o,
  output logic [2:0]                    region_perms_o
);

  localparam int NDesc = (REGION_COUNT < rcbem_pkg::DescRegs) ? REGION_COUNT
                                                               : rcbem_pkg::DescRegs;
  localparam int AW    = $clog2(REGION_COUNT * REGION_BYTES);
  localparam int Rows  = (REGION_COUNT * REGION_BYTES + rcbem_pkg::LaneCount - 1)
                         / rcbem_pkg::LaneCount;
  localparam int RW    = $clog2(Rows);
  localparam int NL    = rcbem_pkg::LaneCount;

  localparam logic [2:0] SClear  = 3'd0;
  localparam logic [2:0] SIdle   = 3'd1;
  localparam logic [2:0] SLookup = 3'd2;
  localparam logic [2:0] SAccess = 3'd3;
  localparam logic [2:0] SResp   = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [RW-1:0]               clr_cnt_q;
  logic [rcbem_pkg::DescW-1:0] desc_q [NDesc];
  logic [1:0]                  op_q;
  logic [31:0]                 addr_q;
  logic [1:0]                  size_q;
  logic [63:0]                 wdata_q;
  rcbem_pkg::region_res_t      res_q, res_d;
  logic [AW-1:0]               index_q, index_d;

  logic [RW-1:0] lane_addr  [NL];
  logic [7:0]    lane_wdata [NL];
  logic [7:0]    lane_rdata [NL];
  logic [NL-1:0] lane_we;

  logic [2:0]    lo;
  logic [RW-1:0] row0;
  logic [63:0]   wl;
  logic [63:0]   left;
  logic [63:0]   rd;
  logic [3:0]    nbytes;
  logic          ok_c;
  logic          store_en;

  assign busy = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NDesc; k++) begin
        desc_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int k = 0; k < NDesc; k++) begin
        if (cfg_index_i == rcbem_pkg::CfgIdxW'(k)) begin
          desc_q[k] <= cfg_wdata_i;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SClear: begin
        if (clr_cnt_q == RW'(Rows - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (start) state_d = SLookup;
      end
      SLookup: state_d = SAccess;
      SAccess: state_d = SResp;
      SResp:   state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SClear;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SClear) clr_cnt_q <= clr_cnt_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q    <= operation_i;
      addr_q  <= address_i;
      size_q  <= access_size_i;
      wdata_q <= write_data_i;
    end
    if (state_q == SLookup) begin
      res_q   <= res_d;
      index_q <= index_d;
    end
  end

  rcbem_region #(
    .REGION_COUNT(REGION_COUNT),
    .REGION_BYTES(REGION_BYTES)
  ) u_region (
    .desc_i (desc_q),
    .addr_i (addr_q),
    .size_i (size_q),
    .res_o  (res_d),
    .index_o(index_d)
  );

  always_comb begin
    case (op_q)
      rcbem_pkg::OpRead:  ok_c = res_q.perms[0];
      rcbem_pkg::OpWrite: ok_c = res_q.perms[1];
      default:            ok_c = 1'b1;
    endcase
  end

  assign store_en = res_q.hit && ok_c &&
                    (op_q inside {rcbem_pkg::OpWrite, rcbem_pkg::OpPreload});

  assign lo     = index_q[2:0];
  assign row0   = RW'(index_q >> 3);
  assign nbytes = rcbem_pkg::access_bytes(size_q);

  always_comb begin
    case (size_q)
      2'd0:    wl = {wdata_q[7:0], 56'b0};
      2'd1:    wl = {wdata_q[15:0], 48'b0};
      2'd2:    wl = {wdata_q[31:0], 32'b0};
      default: wl = wdata_q;
    endcase
  end

  always_comb begin
    for (int j = 0; j < NL; j++) begin
      logic [2:0] i;
      i = 3'(j) - lo;
      if (state_q == SClear) begin
        lane_addr[j]  = clr_cnt_q;
        lane_wdata[j] = 8'h00;
        lane_we[j]    = 1'b1;
      end else begin
        lane_addr[j]  = row0 + RW'(3'(j) < lo);
        lane_wdata[j] = wl[8*(7 - i) +: 8];
        lane_we[j]    = (state_q == SAccess) && store_en && (4'(i) < nbytes);
      end
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    rcbem_ram #(
      .WIDTH(8),
      .DEPTH(Rows)
    ) u_lane (
      .clk_i  (clk_i),
      .we_i   (lane_we[g]),
      .addr_i (lane_addr[g]),
      .wdata_i(lane_wdata[g]),
      .rdata_o(lane_rdata[g])
    );
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      left[8*(7 - i) +: 8] = lane_rdata[3'(i) + lo];
    end
    case (size_q)
      2'd0:    rd = {56'b0, left[63:56]};
      2'd1:    rd = {48'b0, left[63:48]};
      2'd2:    rd = {32'b0, left[63:32]};
      default: rd = left;
    endcase
  end

  assign result_valid_o  = (state_q == SResp);
  assign ok_o            = res_q.hit && ok_c;
  assign read_data_o     = (op_q == rcbem_pkg::OpRead && ok_o) ? rd : 64'b0;
  assign region_hit_o    = res_q.hit;
  assign region_number_o = res_q.number;
  assign region_perms_o  = res_q.perms;

  ok_never_without_hit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ok_o) |-> region_hit_o
  ) else $error("ok without region hit");

  read_data_only_on_read: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && read_data_o != 64'b0) |-> (op_q == rcbem_pkg::OpRead && ok_o)
  ) else $error("read data on non-read or failed access");

  store_write_window: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (lane_we != '0) |-> (state_q == SAccess || state_q == SClear)
  ) else $error("lane write outside access or clear");

  result_follows_access: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == SAccess)
  ) else $error("result strobe without preceding access");

  probe_never_writes: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == SAccess && (op_q == rcbem_pkg::OpProbe || op_q == rcbem_pkg::OpRead))
      |-> (lane_we == '0)
  ) else $error("store written by read or probe");

endmodule
